// ===== hdl/rlsroe_pkg.sv =====
// Package for the RLS resistance and offset estimator.
// Holds payload types, controller commands, operand codes and the update program.
// No dependencies.
package rlsroe_pkg;

    typedef struct packed {
        logic               update_enable;
        logic signed [31:0] current_d;
        logic signed [31:0] current_q;
        logic signed [31:0] voltage_d;
        logic signed [31:0] voltage_q;
    } rls_in_t;

    typedef struct packed {
        logic signed [47:0] est_resistance;
        logic signed [47:0] est_offset;
        logic               singular;
        logic               saturated;
    } rls_out_t;

    localparam int CFG_DATA_W = 47;
    localparam int CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_FORGET_FACTOR      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORGET_RECIPROCAL  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_COVARIANCE = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_RESISTANCE = 8'd3;

    localparam logic [24:0] FORGET_FACTOR_RST      = 25'd16760439;
    localparam logic [25:0] FORGET_RECIPROCAL_RST  = 26'd16794011;
    localparam logic [46:0] INITIAL_COVARIANCE_RST = 47'd16777216000;
    localparam logic [46:0] INITIAL_RESISTANCE_RST = 47'd1132462;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_DIV
    } op_code_t;

    localparam int OPND_W = 6;
    localparam int SCR_DEPTH = 32;

    // Scratch operands, held in the scratch RAM.
    localparam logic [OPND_W-1:0] R_KT00  = 6'd0;
    localparam logic [OPND_W-1:0] R_KT01  = 6'd1;
    localparam logic [OPND_W-1:0] R_KT10  = 6'd2;
    localparam logic [OPND_W-1:0] R_KT11  = 6'd3;
    localparam logic [OPND_W-1:0] R_S00   = 6'd4;
    localparam logic [OPND_W-1:0] R_S01   = 6'd5;
    localparam logic [OPND_W-1:0] R_S10   = 6'd6;
    localparam logic [OPND_W-1:0] R_S11   = 6'd7;
    localparam logic [OPND_W-1:0] R_DET   = 6'd8;
    localparam logic [OPND_W-1:0] R_ADJ01 = 6'd9;
    localparam logic [OPND_W-1:0] R_ADJ10 = 6'd10;
    localparam logic [OPND_W-1:0] R_K00   = 6'd11;
    localparam logic [OPND_W-1:0] R_K01   = 6'd12;
    localparam logic [OPND_W-1:0] R_K10   = 6'd13;
    localparam logic [OPND_W-1:0] R_K11   = 6'd14;
    localparam logic [OPND_W-1:0] R_PS00  = 6'd15;
    localparam logic [OPND_W-1:0] R_PS01  = 6'd16;
    localparam logic [OPND_W-1:0] R_PS10  = 6'd17;
    localparam logic [OPND_W-1:0] R_PS11  = 6'd18;
    localparam logic [OPND_W-1:0] R_A00   = 6'd19;
    localparam logic [OPND_W-1:0] R_A01   = 6'd20;
    localparam logic [OPND_W-1:0] R_A10   = 6'd21;
    localparam logic [OPND_W-1:0] R_A11   = 6'd22;
    localparam logic [OPND_W-1:0] R_T1    = 6'd23;
    localparam logic [OPND_W-1:0] R_T2    = 6'd24;
    localparam logic [OPND_W-1:0] R_E0    = 6'd25;
    localparam logic [OPND_W-1:0] R_E1    = 6'd26;

    // Operands held in datapath registers.
    localparam logic [OPND_W-1:0] SP_P00  = 6'd32;
    localparam logic [OPND_W-1:0] SP_P01  = 6'd33;
    localparam logic [OPND_W-1:0] SP_P10  = 6'd34;
    localparam logic [OPND_W-1:0] SP_P11  = 6'd35;
    localparam logic [OPND_W-1:0] SP_TH0  = 6'd36;
    localparam logic [OPND_W-1:0] SP_TH1  = 6'd37;
    localparam logic [OPND_W-1:0] SP_X    = 6'd38;
    localparam logic [OPND_W-1:0] SP_Y    = 6'd39;
    localparam logic [OPND_W-1:0] SP_VD   = 6'd40;
    localparam logic [OPND_W-1:0] SP_VQ   = 6'd41;
    localparam logic [OPND_W-1:0] SP_ONE  = 6'd42;
    localparam logic [OPND_W-1:0] SP_ZERO = 6'd43;
    localparam logic [OPND_W-1:0] SP_LAM  = 6'd44;
    localparam logic [OPND_W-1:0] SP_RLAM = 6'd45;

    typedef struct packed {
        op_code_t          opc;
        logic [OPND_W-1:0] a;
        logic [OPND_W-1:0] b;
        logic [OPND_W-1:0] dst;
    } op_t;

    localparam int NUM_OPS = 95;
    localparam int PC_W = 7;
    localparam logic [PC_W-1:0] PC_DET = 7'd28;
    localparam logic [PC_W-1:0] PC_LAST = 7'd94;

    localparam op_t PROG [NUM_OPS] = '{
        '{OP_MUL, SP_P00, SP_X, R_T1},   '{OP_MUL, SP_P01, SP_ONE, R_T2},
        '{OP_ADD, R_T1, R_T2, R_KT00},
        '{OP_MUL, SP_P00, SP_Y, R_T1},   '{OP_MUL, SP_P01, SP_ONE, R_T2},
        '{OP_ADD, R_T1, R_T2, R_KT01},
        '{OP_MUL, SP_P10, SP_X, R_T1},   '{OP_MUL, SP_P11, SP_ONE, R_T2},
        '{OP_ADD, R_T1, R_T2, R_KT10},
        '{OP_MUL, SP_P10, SP_Y, R_T1},   '{OP_MUL, SP_P11, SP_ONE, R_T2},
        '{OP_ADD, R_T1, R_T2, R_KT11},
        '{OP_MUL, SP_X, R_KT00, R_T1},   '{OP_MUL, SP_ONE, R_KT10, R_T2},
        '{OP_ADD, R_T1, R_T2, R_S00},
        '{OP_MUL, SP_X, R_KT01, R_T1},   '{OP_MUL, SP_ONE, R_KT11, R_T2},
        '{OP_ADD, R_T1, R_T2, R_S01},
        '{OP_MUL, SP_Y, R_KT00, R_T1},   '{OP_MUL, SP_ONE, R_KT10, R_T2},
        '{OP_ADD, R_T1, R_T2, R_S10},
        '{OP_MUL, SP_Y, R_KT01, R_T1},   '{OP_MUL, SP_ONE, R_KT11, R_T2},
        '{OP_ADD, R_T1, R_T2, R_S11},
        '{OP_ADD, R_S00, SP_LAM, R_S00}, '{OP_ADD, R_S11, SP_LAM, R_S11},
        '{OP_MUL, R_S00, R_S11, R_T1},   '{OP_MUL, R_S01, R_S10, R_T2},
        '{OP_SUB, R_T1, R_T2, R_DET},
        '{OP_SUB, SP_ZERO, R_S01, R_ADJ01}, '{OP_SUB, SP_ZERO, R_S10, R_ADJ10},
        '{OP_MUL, R_KT00, R_S11, R_T1},  '{OP_MUL, R_KT01, R_ADJ10, R_T2},
        '{OP_ADD, R_T1, R_T2, R_K00},
        '{OP_MUL, R_KT00, R_ADJ01, R_T1}, '{OP_MUL, R_KT01, R_S00, R_T2},
        '{OP_ADD, R_T1, R_T2, R_K01},
        '{OP_MUL, R_KT10, R_S11, R_T1},  '{OP_MUL, R_KT11, R_ADJ10, R_T2},
        '{OP_ADD, R_T1, R_T2, R_K10},
        '{OP_MUL, R_KT10, R_ADJ01, R_T1}, '{OP_MUL, R_KT11, R_S00, R_T2},
        '{OP_ADD, R_T1, R_T2, R_K11},
        '{OP_DIV, R_K00, R_DET, R_K00},  '{OP_DIV, R_K01, R_DET, R_K01},
        '{OP_DIV, R_K10, R_DET, R_K10},  '{OP_DIV, R_K11, R_DET, R_K11},
        '{OP_MUL, SP_P00, SP_RLAM, R_PS00}, '{OP_MUL, SP_P01, SP_RLAM, R_PS01},
        '{OP_MUL, SP_P10, SP_RLAM, R_PS10}, '{OP_MUL, SP_P11, SP_RLAM, R_PS11},
        '{OP_MUL, R_K00, SP_X, R_T1},    '{OP_MUL, R_K01, SP_Y, R_T2},
        '{OP_ADD, R_T1, R_T2, R_A00},
        '{OP_MUL, R_K00, SP_ONE, R_T1},  '{OP_MUL, R_K01, SP_ONE, R_T2},
        '{OP_ADD, R_T1, R_T2, R_A01},
        '{OP_MUL, R_K10, SP_X, R_T1},    '{OP_MUL, R_K11, SP_Y, R_T2},
        '{OP_ADD, R_T1, R_T2, R_A10},
        '{OP_MUL, R_K10, SP_ONE, R_T1},  '{OP_MUL, R_K11, SP_ONE, R_T2},
        '{OP_ADD, R_T1, R_T2, R_A11},
        '{OP_SUB, SP_ONE, R_A00, R_A00}, '{OP_SUB, SP_ZERO, R_A01, R_A01},
        '{OP_SUB, SP_ZERO, R_A10, R_A10}, '{OP_SUB, SP_ONE, R_A11, R_A11},
        '{OP_MUL, R_A00, R_PS00, R_T1},  '{OP_MUL, R_A01, R_PS10, R_T2},
        '{OP_ADD, R_T1, R_T2, SP_P00},
        '{OP_MUL, R_A00, R_PS01, R_T1},  '{OP_MUL, R_A01, R_PS11, R_T2},
        '{OP_ADD, R_T1, R_T2, SP_P01},
        '{OP_MUL, R_A10, R_PS00, R_T1},  '{OP_MUL, R_A11, R_PS10, R_T2},
        '{OP_ADD, R_T1, R_T2, SP_P10},
        '{OP_MUL, R_A10, R_PS01, R_T1},  '{OP_MUL, R_A11, R_PS11, R_T2},
        '{OP_ADD, R_T1, R_T2, SP_P11},
        '{OP_MUL, SP_X, SP_TH0, R_T1},   '{OP_MUL, SP_ONE, SP_TH1, R_T2},
        '{OP_ADD, R_T1, R_T2, R_T1},     '{OP_SUB, SP_VD, R_T1, R_E0},
        '{OP_MUL, SP_Y, SP_TH0, R_T1},   '{OP_MUL, SP_ONE, SP_TH1, R_T2},
        '{OP_ADD, R_T1, R_T2, R_T1},     '{OP_SUB, SP_VQ, R_T1, R_E1},
        '{OP_MUL, R_K00, R_E0, R_T1},    '{OP_MUL, R_K01, R_E1, R_T2},
        '{OP_ADD, R_T1, R_T2, R_T1},     '{OP_ADD, SP_TH0, R_T1, SP_TH0},
        '{OP_MUL, R_K10, R_E0, R_T1},    '{OP_MUL, R_K11, R_E1, R_T2},
        '{OP_ADD, R_T1, R_T2, R_T1},     '{OP_ADD, SP_TH1, R_T1, SP_TH1}
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_START,
        ST_WAIT,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic set_singular;
        logic publish;
        op_t  op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic done;
        logic result_zero;
    } dp_status_t;

endpackage

// ===== hdl/rlsroe_ram.sv =====
// Generic RAM with one write port and two registered read ports.
// No dependencies.
module rlsroe_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end
endmodule

// ===== hdl/rlsroe_datapath.sv =====
// Datapath of the estimator: configuration, state, scratch RAM and the
// multiply, divide and saturating add units. Depends on rlsroe_pkg, rlsroe_ram.
module rlsroe_datapath #(
    parameter int FRAC_BITS = 24,
    parameter int WORD_WIDTH = 48
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rlsroe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rlsroe_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  rlsroe_pkg::rls_in_t                 s_payload,
    output rlsroe_pkg::rls_out_t                m_payload,
    input  rlsroe_pkg::ctrl_cmd_t               cmd,
    output rlsroe_pkg::dp_status_t              st
);
    import rlsroe_pkg::*;

    localparam int W = WORD_WIDTH;
    localparam int F = FRAC_BITS;
    localparam int NW = W + F;
    localparam int CNT_W = $clog2(NW + 1);
    localparam int SHL = (F >= 24) ? F - 24 : 0;
    localparam int SHR = (F >= 24) ? 0 : 24 - F;

    function automatic logic [W:0] sat_wide(input logic signed [79:0] v);
        logic signed [79:0] hi;
        logic signed [79:0] lo;
        hi = (80'sd1 <<< (W - 1)) - 80'sd1;
        lo = -hi - 80'sd1;
        if (v > hi) return {1'b1, hi[W-1:0]};
        if (v < lo) return {1'b1, lo[W-1:0]};
        return {1'b0, v[W-1:0]};
    endfunction

    function automatic logic [W-1:0] mag(input logic [W-1:0] a);
        return a[W-1] ? W'(-a) : a;
    endfunction

    function automatic logic [W:0] from_mag(input logic neg, input logic [127:0] m);
        logic [127:0] lim;
        logic [127:0] v;
        logic         c;
        logic [W-1:0] r;
        lim = (128'd1 << (W - 1)) - 128'd1 + {127'd0, neg};
        c = (m > lim);
        v = c ? lim : m;
        r = v[W-1:0];
        return {c, neg ? W'(-r) : r};
    endfunction

    function automatic logic [W:0] sat_addsub(input logic [W-1:0] a, input logic [W-1:0] b,
                                              input logic sub);
        logic signed [W:0] s;
        logic signed [W:0] hi;
        logic signed [W:0] lo;
        s = sub ? ($signed({a[W-1], a}) - $signed({b[W-1], b}))
                : ($signed({a[W-1], a}) + $signed({b[W-1], b}));
        hi = $signed({2'b00, {(W - 1){1'b1}}});
        lo = $signed({2'b11, {(W - 1){1'b0}}});
        if (s > hi) return {1'b1, hi[W-1:0]};
        if (s < lo) return {1'b1, lo[W-1:0]};
        return {1'b0, s[W-1:0]};
    endfunction

    localparam logic [W:0] ICOV_RST_SAT = sat_wide(80'(INITIAL_COVARIANCE_RST));
    localparam logic [W:0] IRES_RST_SAT = sat_wide(80'(INITIAL_RESISTANCE_RST));
    localparam logic [W-1:0] ONE = W'(1) << F;

    logic [24:0]   ff_reg;
    logic [25:0]   fr_reg;

    logic [W-1:0]        p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [W-1:0] th0_reg, th1_reg;
    logic [W-1:0]        x_reg, y_reg, vd_reg, vq_reg;
    logic                en_reg, sing_reg, clip_reg;
    rls_out_t            out_reg;

    logic [W-1:0] spa_reg, spb_reg;
    logic         sela_reg, selb_reg;
    logic [W-1:0] ram_a, ram_b;

    logic         run_reg;
    op_code_t     opc_reg;
    logic [OPND_W-1:0] dst_reg;
    logic [W-1:0] a_reg, b_reg;
    logic         neg_reg;
    logic [63:0]  ma_reg, mb_reg, pp_reg;
    logic [1:0]   pidx_reg;
    logic [127:0] acc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NW-1:0] num_reg, q_reg;
    logic [W-1:0] rem_reg;

    logic [W:0] cvt_x, cvt_y, cvt_vd, cvt_vq, cvt_lam, cvt_rlam, cvt_icov, cvt_ires;
    logic [W-1:0] opa, opb;
    logic [W-1:0] spec_a, spec_b;
    logic         wr_en;
    logic [W:0]   wr_res;
    logic [127:0] mul_round;
    logic [127:0] div_round;
    logic [W:0]   rem_sh;
    logic         div_ge;
    logic [1:0]   pp_shift;

    function automatic logic [W-1:0] special(input logic [OPND_W-1:0] addr,
                                             input logic [W-1:0] p00, input logic [W-1:0] p01,
                                             input logic [W-1:0] p10, input logic [W-1:0] p11,
                                             input logic [W-1:0] t0, input logic [W-1:0] t1,
                                             input logic [W-1:0] x, input logic [W-1:0] y,
                                             input logic [W-1:0] vd, input logic [W-1:0] vq,
                                             input logic [W-1:0] lam, input logic [W-1:0] rlam);
        logic [W-1:0] v;
        case (addr)
            SP_P00:  v = p00;
            SP_P01:  v = p01;
            SP_P10:  v = p10;
            SP_P11:  v = p11;
            SP_TH0:  v = t0;
            SP_TH1:  v = t1;
            SP_X:    v = x;
            SP_Y:    v = y;
            SP_VD:   v = vd;
            SP_VQ:   v = vq;
            SP_ONE:  v = ONE;
            SP_LAM:  v = lam;
            SP_RLAM: v = rlam;
            default: v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        cvt_x = sat_wide(80'(s_payload.current_d) <<< (F - 16));
        cvt_y = sat_wide(80'(s_payload.current_q) <<< (F - 16));
        cvt_vd = sat_wide(80'(s_payload.voltage_d) <<< (F - 16));
        cvt_vq = sat_wide(80'(s_payload.voltage_q) <<< (F - 16));
        cvt_lam = sat_wide($signed((80'(ff_reg) << SHL) >> SHR));
        cvt_rlam = sat_wide($signed((80'(fr_reg) << SHL) >> SHR));
        cvt_icov = sat_wide(80'(cfg_wdata));
        cvt_ires = sat_wide(80'(cfg_wdata));
        spec_a = special(cmd.op.a, p00_reg, p01_reg, p10_reg, p11_reg, th0_reg, th1_reg,
                         x_reg, y_reg, vd_reg, vq_reg, cvt_lam[W-1:0], cvt_rlam[W-1:0]);
        spec_b = special(cmd.op.b, p00_reg, p01_reg, p10_reg, p11_reg, th0_reg, th1_reg,
                         x_reg, y_reg, vd_reg, vq_reg, cvt_lam[W-1:0], cvt_rlam[W-1:0]);
        opa = sela_reg ? spa_reg : ram_a;
        opb = selb_reg ? spb_reg : ram_b;
    end

    always_comb begin
        mul_round = (acc_reg + (128'd1 << (F - 1))) >> F;
        div_round = 128'(q_reg) + 128'({rem_reg, 1'b0} >= {1'b0, mb_reg[W-1:0]});
        rem_sh = {rem_reg, num_reg[NW-1]};
        div_ge = (rem_sh >= {1'b0, mb_reg[W-1:0]});
        pp_shift = {pidx_reg[1] & pidx_reg[0], pidx_reg[1] ^ pidx_reg[0]};
        wr_en = 1'b0;
        wr_res = '0;
        if (run_reg) begin
            case (opc_reg)
                OP_ADD: begin
                    wr_en = 1'b1;
                    wr_res = sat_addsub(a_reg, b_reg, 1'b0);
                end
                OP_SUB: begin
                    wr_en = 1'b1;
                    wr_res = sat_addsub(a_reg, b_reg, 1'b1);
                end
                OP_MUL: begin
                    wr_en = (cnt_reg == CNT_W'(5));
                    wr_res = from_mag(neg_reg, mul_round);
                end
                default: begin
                    wr_en = (cnt_reg == CNT_W'(NW));
                    wr_res = from_mag(neg_reg, div_round);
                end
            endcase
        end
    end

    assign st.done = wr_en;
    assign st.result_zero = (wr_res[W-1:0] == '0);

    rlsroe_ram #(
        .WIDTH(W),
        .DEPTH(SCR_DEPTH)
    ) u_scratch (
        .aclk    (aclk),
        .we      (wr_en & ~dst_reg[OPND_W-1]),
        .waddr   (dst_reg[$clog2(SCR_DEPTH)-1:0]),
        .wdata   (wr_res[W-1:0]),
        .raddr_a (cmd.op.a[$clog2(SCR_DEPTH)-1:0]),
        .raddr_b (cmd.op.b[$clog2(SCR_DEPTH)-1:0]),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    always_ff @(posedge aclk) begin
        spa_reg <= spec_a;
        spb_reg <= spec_b;
        sela_reg <= cmd.op.a[OPND_W-1];
        selb_reg <= cmd.op.b[OPND_W-1];

        if (cmd.load) begin
            x_reg <= cvt_x[W-1:0];
            y_reg <= cvt_y[W-1:0];
            vd_reg <= cvt_vd[W-1:0];
            vq_reg <= cvt_vq[W-1:0];
        end

        if (cmd.start) begin
            opc_reg <= cmd.op.opc;
            dst_reg <= cmd.op.dst;
            a_reg <= opa;
            b_reg <= opb;
            neg_reg <= opa[W-1] ^ opb[W-1];
            ma_reg <= 64'(mag(opa));
            mb_reg <= 64'(mag(opb));
            num_reg <= {mag(opa), {F{1'b0}}};
            rem_reg <= '0;
            q_reg <= '0;
            acc_reg <= '0;
        end else if (run_reg) begin
            if (opc_reg == OP_MUL) begin
                if (cnt_reg < CNT_W'(4)) begin
                    pp_reg <= (cnt_reg[1] ? ma_reg[63:32] : ma_reg[31:0])
                            * (cnt_reg[0] ? mb_reg[63:32] : mb_reg[31:0]);
                    pidx_reg <= cnt_reg[1:0];
                end
                if (cnt_reg >= CNT_W'(1) && cnt_reg <= CNT_W'(4)) begin
                    acc_reg <= acc_reg + (128'(pp_reg) << {pp_shift, 5'b0});
                end
            end else if (opc_reg == OP_DIV && cnt_reg < CNT_W'(NW)) begin
                rem_reg <= div_ge ? W'(rem_sh - {1'b0, mb_reg[W-1:0]}) : rem_sh[W-1:0];
                q_reg <= {q_reg[NW-2:0], div_ge};
                num_reg <= {num_reg[NW-2:0], 1'b0};
            end
        end

        if (cmd.publish) begin
            out_reg.est_resistance <= 48'(th0_reg);
            out_reg.est_offset <= 48'(th1_reg);
            out_reg.singular <= sing_reg;
            out_reg.saturated <= en_reg & ~sing_reg & clip_reg;
        end

        if (!aresetn) begin
            ff_reg <= FORGET_FACTOR_RST;
            fr_reg <= FORGET_RECIPROCAL_RST;
            p00_reg <= ICOV_RST_SAT[W-1:0];
            p01_reg <= '0;
            p10_reg <= '0;
            p11_reg <= ICOV_RST_SAT[W-1:0];
            th0_reg <= IRES_RST_SAT[W-1:0];
            th1_reg <= '0;
            en_reg <= 1'b0;
            sing_reg <= 1'b0;
            clip_reg <= 1'b0;
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_FORGET_FACTOR:     ff_reg <= cfg_wdata[24:0];
                    CFG_FORGET_RECIPROCAL: fr_reg <= cfg_wdata[25:0];
                    CFG_INITIAL_COVARIANCE: begin
                        p00_reg <= cvt_icov[W-1:0];
                        p01_reg <= '0;
                        p10_reg <= '0;
                        p11_reg <= cvt_icov[W-1:0];
                    end
                    CFG_INITIAL_RESISTANCE: begin
                        th0_reg <= cvt_ires[W-1:0];
                        th1_reg <= '0;
                    end
                    default: ;
                endcase
            end
            if (cmd.load) begin
                en_reg <= s_payload.update_enable;
                sing_reg <= 1'b0;
                clip_reg <= cvt_x[W] | cvt_y[W] | cvt_vd[W] | cvt_vq[W]
                          | cvt_lam[W] | cvt_rlam[W];
            end
            if (cmd.set_singular) begin
                sing_reg <= 1'b1;
            end
            if (cmd.start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (wr_en) begin
                run_reg <= 1'b0;
                clip_reg <= clip_reg | wr_res[W];
                unique case (dst_reg)
                    SP_P00:  p00_reg <= wr_res[W-1:0];
                    SP_P01:  p01_reg <= wr_res[W-1:0];
                    SP_P10:  p10_reg <= wr_res[W-1:0];
                    SP_P11:  p11_reg <= wr_res[W-1:0];
                    SP_TH0:  th0_reg <= wr_res[W-1:0];
                    SP_TH1:  th1_reg <= wr_res[W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign m_payload = out_reg;
endmodule

// ===== hdl/rlsroe_ctrl.sv =====
// Controller of the estimator: sequences the update program over the datapath
// and runs both handshakes. Depends on rlsroe_pkg.
module rlsroe_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_enable,
    output logic                   m_valid,
    input  logic                   m_ready,
    output rlsroe_pkg::ctrl_cmd_t  cmd,
    input  rlsroe_pkg::dp_status_t st
);
    import rlsroe_pkg::*;

    ctrl_state_t     state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pc_reg <= pc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pc_next = pc_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        s_ready = 1'b0;
        cmd.load = 1'b0;
        cmd.start = 1'b0;
        cmd.set_singular = 1'b0;
        cmd.publish = 1'b0;
        cmd.op = PROG[pc_reg];
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    pc_next = '0;
                    state_next = s_enable ? ST_FETCH : ST_FINISH;
                end
            end
            ST_FETCH: state_next = ST_START;
            ST_START: begin
                cmd.start = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (st.done) begin
                    if (pc_reg == PC_DET && st.result_zero) begin
                        cmd.set_singular = 1'b1;
                        state_next = ST_FINISH;
                    end else if (pc_reg == PC_LAST) begin
                        state_next = ST_FINISH;
                    end else begin
                        pc_next = pc_reg + PC_W'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.publish = 1'b1;
                    m_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid = m_valid_reg;

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        st.done |-> state_reg == ST_WAIT)
        else $error("datapath finished an operation outside the wait state");

    a_publish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> (!m_valid_reg || m_ready))
        else $error("result published over a pending transfer");

    a_last_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT && st.done && pc_reg == PC_LAST) |=> state_reg == ST_FINISH)
        else $error("program end did not finish the item");

    a_singular_at_det: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.set_singular |=> state_reg == ST_FINISH && pc_reg == PC_DET)
        else $error("singular flag raised away from the determinant step");
endmodule

// ===== hdl/rls_resistance_offset_estimator_core.sv =====
// Top level of the RLS winding resistance and voltage offset estimator.
// Depends on rlsroe_pkg, rlsroe_ctrl, rlsroe_datapath.
//
// One input transfer yields exactly one result transfer carrying the resistance
// and offset estimates after the sample. The block works on one sample at a
// time: a disabled sample skips the program; an enabled sample runs a fixed
// program of 95 operations on one shared multiply/divide/add datapath, where a
// multiply forms four 32x32 partial products, a saturating add or subtract
// clamps its result and each of the four divisions produces one quotient bit
// per cycle. A singular sample ends at the determinant step. A finished result
// waits in an output register, so the next sample is taken while it is pending.
// Configuration writes must be made only while no sample is in flight.
module rls_resistance_offset_estimator_core #(
    parameter int FRAC_BITS = 24,
    parameter int WORD_WIDTH = 48
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [rlsroe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rlsroe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  rlsroe_pkg::rls_in_t                s_payload,
    output logic                               m_valid,
    input  logic                               m_ready,
    output rlsroe_pkg::rls_out_t               m_payload
);
    import rlsroe_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t st;

    rlsroe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_enable (s_payload.update_enable),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .st       (st)
    );

    rlsroe_datapath #(
        .FRAC_BITS  (FRAC_BITS),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_payload (s_payload),
        .m_payload (m_payload),
        .cmd       (cmd),
        .st        (st)
    );
endmodule
